FILE: src/sha256d_pkg.sv
package sha256d_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_FINISH,
    ST_OUT
  } back_state_t;

  // one queued word, bytes already split off
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    logic        cmp;
  } word_beat_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: src/sha256d_queue.sv
module sha256d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_valid,
  output logic                    wr_ready,
  input  sha256d_pkg::word_beat_t wr_data,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output sha256d_pkg::word_beat_t rd_data
);
  import sha256d_pkg::*;

  localparam int AW = $clog2(DEPTH);

  word_beat_t       mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;
  logic             push, pop;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rptr];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

FILE: src/sha256d_core.sv
// Back part: packs bytes into the block, pads, runs both compressions with one
// round per cycle, compares against the target and holds the result beat.
module sha256d_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sha256d_pkg::word_beat_t in_data,
  input  logic [255:0]            target,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [255:0]            out_digest,
  output logic                    out_below
);
  import sha256d_pkg::*;

  back_state_t state, state_next;

  logic [255:0] chain;
  logic [31:0]  blk [16];
  logic [31:0]  w [16];
  logic [63:0]  nbytes;      // message byte count
  logic [63:0]  bitlen;
  logic [2:0]   take;        // bytes still to absorb from held word
  logic [31:0]  hold;
  logic         hold_last, hold_cmp, padding, second, have_word;
  logic         final_pass;  // second compression running
  logic [1:0]   pad_phase;   // 0: 0x80, 1: zeros, 2: length
  logic [2:0]   len_idx;
  logic [5:0]   rnd;
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [31:0]  t1, t2, wn, s0, s1;
  logic [7:0]   byte_in;
  logic [5:0]   pos;
  logic [255:0] h2;
  logic         below;

  assign pos = nbytes[5:0];

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + sha_k(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  // byte to absorb this cycle in ST_IDLE
  always_comb begin
    byte_in = 8'h00;
    if (have_word) begin
      byte_in = hold[31:24];
    end else if (padding) begin
      unique case (pad_phase)
        2'd0: byte_in = 8'h80;
        2'd2: byte_in = bitlen[63 - 8*len_idx -: 8];
        default: byte_in = 8'h00;
      endcase
    end
  end

  logic absorbing;
  assign absorbing = (state == ST_IDLE) && (have_word || padding);
  assign in_ready = (state == ST_IDLE) && !have_word && !padding;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (absorbing && pos == 6'd63) state_next = ST_ROUND;
      ST_ROUND:  if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        priority if (second) state_next = ST_ROUND;
        else if (final_pass) state_next = ST_FINISH;
        else state_next = ST_IDLE;
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign out_valid = state == ST_OUT;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h2[255 - 32*i -: 32] = SHA_IV[255 - 32*i -: 32];
    end
    h2 = {chain[255:224] + a, chain[223:192] + b, chain[191:160] + c,
          chain[159:128] + d, chain[127:96] + e, chain[95:64] + f,
          chain[63:32] + g, chain[31:0] + h};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= SHA_IV;
      nbytes <= '0;
      have_word <= 1'b0;
      padding <= 1'b0;
      second <= 1'b0;
      final_pass <= 1'b0;
      rnd <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            hold <= in_data.data;
            take <= (in_data.nbytes > 3'd4) ? 3'd4 : in_data.nbytes;
            hold_last <= in_data.last;
            hold_cmp <= in_data.cmp;
            have_word <= (in_data.nbytes != 3'd0);
            if (in_data.nbytes == 3'd0 && in_data.last) begin
              padding <= 1'b1;
              pad_phase <= 2'd0;
              bitlen <= {nbytes[60:0], 3'b000};
            end
          end
          if (absorbing) begin
            blk[pos[5:2]][31 - 8*pos[1:0] -: 8] <= byte_in;
            nbytes <= nbytes + 64'd1;
            if (have_word) begin
              hold <= {hold[23:0], 8'h00};
              take <= take - 3'd1;
              if (take == 3'd1) begin
                have_word <= 1'b0;
                if (hold_last) begin
                  padding <= 1'b1;
                  pad_phase <= 2'd0;
                  bitlen <= {nbytes[60:0] + 61'd1, 3'b000};
                end
              end
            end else begin
              unique case (pad_phase)
                2'd0, 2'd1: begin
                  if (pos == 6'd55) begin
                    pad_phase <= 2'd2;
                    len_idx <= '0;
                  end else begin
                    pad_phase <= 2'd1;
                  end
                end
                default: begin
                  len_idx <= len_idx + 3'd1;
                  if (len_idx == 3'd7) begin
                    padding <= 1'b0;
                    second <= 1'b1;
                  end
                end
              endcase
            end
            if (pos == 6'd63) begin
              for (int i = 0; i < 15; i++) w[i] <= blk[i];
              w[15] <= {blk[15][31:8], byte_in};
              {a, b, c, d, e, f, g, h} <= chain;
              rnd <= '0;
            end
          end
        end
        ST_ROUND: begin
          {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= wn;
          rnd <= rnd + 6'd1;
        end
        ST_ADD: begin
          priority if (second) begin
            // second hash: digest, pad and length in one block
            chain <= SHA_IV;
            for (int i = 0; i < 8; i++) w[i] <= h2[255 - 32*i -: 32];
            w[8] <= 32'h80000000;
            for (int i = 9; i < 15; i++) w[i] <= '0;
            w[15] <= 32'd256;
            {a, b, c, d, e, f, g, h} <= SHA_IV;
            rnd <= '0;
            second <= 1'b0;
            final_pass <= 1'b1;
            nbytes <= '0;
          end else if (final_pass) begin
            // h2 already holds the final digest, picked up in ST_FINISH
            final_pass <= 1'b0;
          end else begin
            chain <= h2;
          end
        end
        ST_FINISH: begin
          out_digest <= h2;
          out_below <= hold_cmp && below;
          chain <= SHA_IV;
        end
        default: ;
      endcase
    end
  end

  // digest byte 0 sits in the top bits, same as the target
  assign below = h2 < target;
endmodule

FILE: src/double_sha256_target_check.sv
// Double SHA-256 with compact-target check. Message words enter on s_axis
// into a 4-deep queue; the core latches one word at a time and absorbs one
// byte per cycle while no compression runs, taking the next word only once
// the held one is absorbed. Each 64-byte block runs its rounds and then an
// add. The last word pads the message, runs the second hash, registers the
// result and delivers one beat on m_axis. Throughput is set by the single
// shared round unit. Write cfg only when idle.
module double_sha256_target_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // data_word[31:0], bytes_valid[34:32], pad
  input  logic         s_axis_tlast,   // last_word
  input  logic         s_axis_tuser,   // compare_enable
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,   // digest_part0..3 from low bits
  output logic         m_axis_tuser,   // below_target
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import sha256d_pkg::*;

  logic [255:0] target, target_next;
  logic [255:0] dig;
  word_beat_t   qin, qout;
  logic         qv, qr;
  logic [7:0]   ex;

  assign cfg_ready = 1'b1;
  assign ex = cfg_data[31:24];

  always_comb begin
    target_next = '0;
    if (ex >= 8'd3 && ex <= 8'd32)
      target_next[8*ex - 1 -: 24] = cfg_data[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target <= target_next;
    end
  end

  assign qin = '{data: s_axis_tdata[31:0], nbytes: s_axis_tdata[34:32],
                 last: s_axis_tlast, cmp: s_axis_tuser};

  sha256d_queue #(.DEPTH(4)) u_q (
    .clk, .rst, .wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready), .wr_data(qin),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qout)
  );

  sha256d_core u_core (
    .clk, .rst, .in_valid(qv), .in_ready(qr), .in_data(qout), .target,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_digest(dig),
    .out_below(m_axis_tuser)
  );

  assign m_axis_tdata = {dig[63:0], dig[127:64], dig[191:128], dig[255:192]};

`ifndef SYNTHESIS
  a_no_cmp_below: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("double beat");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat dropped");
`endif
endmodule

FILE: dv/double_sha256_target_check_tb.sv
`timescale 1ns / 1ps

module double_sha256_target_check_tb;
  import sha256d_pkg::*;

  typedef struct packed {
    logic [63:0] part0;
    logic [63:0] part1;
    logic [63:0] part2;
    logic [63:0] part3;
    logic        below;
  } digest_res_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        cmp;
    bit          is_cfg;
    logic [31:0] cfg_word;
    bit          drain;
  } word_item_t;

  localparam logic [31:0] IV_W [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam int MIN_EXP = 3;
  localparam int MAX_EXP = 32;
  localparam int SETTLE_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  double_sha256_target_check dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0]  hash_chain [8];
  logic [31:0]  blk_words [16];
  logic [63:0]  msg_bytes;
  logic [255:0] target_bits;

  word_item_t   pending_words [$];
  digest_res_t  expected_digests [$];
  int           fail_count = 0;
  bit           stim_done = 1'b0;
  bit           quiet_tail = 1'b0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress(inout logic [31:0] h [8], input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
  endtask

  task automatic push_byte(logic [7:0] byt);
    int pos;
    pos = msg_bytes[5:0];
    blk_words[pos/4][8*(3 - pos%4) +: 8] = byt;
    msg_bytes++;
    if (msg_bytes[5:0] == 0) sha_compress(hash_chain, blk_words);
  endtask

  task automatic new_message();
    for (int i = 0; i < 8; i++) hash_chain[i] = IV_W[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    msg_bytes = '0;
  endtask

  task automatic load_target(logic [31:0] compact);
    int ex;
    ex = compact[31:24];
    target_bits = '0;
    // byte 0 is the msb of the 256-bit target
    if (ex >= MIN_EXP && ex <= MAX_EXP)
      for (int i = 0; i < 3; i++)
        target_bits[255 - 8*(32 - ex + i) -: 8] = compact[23 - 8*i -: 8];
  endtask

  task automatic predict_word(word_item_t it);
    int nb;
    logic [63:0] bitlen;
    logic [31:0] h2 [8];
    logic [31:0] second [16];
    logic [255:0] dig;
    digest_res_t r;
    nb = (it.nbytes > 4) ? 4 : it.nbytes;
    for (int i = 0; i < nb; i++) push_byte(it.word[31 - 8*i -: 8]);
    if (!it.last) return;
    bitlen = msg_bytes << 3;
    push_byte(8'h80);
    while (msg_bytes[5:0] != 56) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(bitlen[63 - 8*i -: 8]);
    for (int i = 0; i < 16; i++) second[i] = '0;
    for (int i = 0; i < 8; i++) second[i] = hash_chain[i];
    second[8] = 32'h80000000;
    second[15] = 32'd256;
    for (int i = 0; i < 8; i++) h2[i] = IV_W[i];
    sha_compress(h2, second);
    dig = {h2[0], h2[1], h2[2], h2[3], h2[4], h2[5], h2[6], h2[7]};
    r.part0 = dig[255:192]; r.part1 = dig[191:128];
    r.part2 = dig[127:64];  r.part3 = dig[63:0];
    r.below = it.cmp && (dig < target_bits);
    expected_digests.push_back(r);
    new_message();
  endtask

  // ---------------- driver ----------------
  int   src_gap = 0;
  bit   cfg_busy = 1'b0;
  bit   drain_wait = 1'b0;
  int   drain_cnt = 0;
  word_item_t cur;

  // handshake flags captured at the rising edge
  bit s_axis_tready_seen = 1'b0;
  bit cfg_ready_seen = 1'b0;

  always @(posedge clk) begin
    s_axis_tready_seen <= !rst && s_axis_tvalid && s_axis_tready;
    cfg_ready_seen <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_word(cur);
      if (cfg_valid && cfg_ready) load_target(cfg_data);
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (cfg_valid) begin
        if (cfg_ready_seen) cfg_valid <= 1'b0;
      end else if (s_axis_tvalid && !s_axis_tready_seen) begin
        // hold current beat
      end else if (drain_wait) begin
        if (expected_digests.size() == 0) begin
          if (drain_cnt >= SETTLE_CYCLES) drain_wait <= 1'b0;
          else drain_cnt <= drain_cnt + 1;
        end
        if (s_axis_tready_seen) s_axis_tvalid <= 1'b0;
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        if (s_axis_tready_seen) s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur = pending_words.pop_front();
        if (cur.drain || cur.is_cfg) begin
          if (s_axis_tready_seen) s_axis_tvalid <= 1'b0;
          if (cur.is_cfg) begin
            // config goes out after the block has drained
            pending_words.push_front('{word: 0, nbytes: 0, last: 0, cmp: 0, is_cfg: 1'b0,
                                       cfg_word: cur.cfg_word, drain: 1'b0});
            pending_words[0].is_cfg = 1'b1;
            pending_words[0].drain = 1'b0;
            if (cur.drain) begin
              drain_wait <= 1'b1;
              drain_cnt <= 0;
            end else begin
              void'(pending_words.pop_front());
              cfg_data <= cur.cfg_word;
              cfg_valid <= 1'b1;
            end
          end else begin
            drain_wait <= 1'b1;
            drain_cnt <= 0;
          end
        end else begin
          s_axis_tdata <= {5'b0, cur.nbytes, cur.word};
          s_axis_tlast <= cur.last;
          s_axis_tuser <= cur.cmp;
          s_axis_tvalid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 13);
        end
      end else begin
        if (s_axis_tready_seen) s_axis_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------
  int sink_gap = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        sink_gap <= $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digest_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.part0 = m_axis_tdata[63:0];
      got.part1 = m_axis_tdata[127:64];
      got.part2 = m_axis_tdata[191:128];
      got.part3 = m_axis_tdata[255:192];
      got.below = m_axis_tuser;
      if (expected_digests.size() == 0) begin
        $display("%0t: unexpected digest beat, got %h", $time, got);
        fail_count++;
      end else begin
        want = expected_digests.pop_front();
        if (got.part0 !== want.part0)
          $display("%0t: part0 expected %h actual %h", $time, want.part0, got.part0);
        if (got.part1 !== want.part1)
          $display("%0t: part1 expected %h actual %h", $time, want.part1, got.part1);
        if (got.part2 !== want.part2)
          $display("%0t: part2 expected %h actual %h", $time, want.part2, got.part2);
        if (got.part3 !== want.part3)
          $display("%0t: part3 expected %h actual %h", $time, want.part3, got.part3);
        if (got.below !== want.below)
          $display("%0t: below_target expected %b actual %b", $time, want.below, got.below);
        if (got !== want) fail_count++;
      end
    end
  end

  // ---------------- stimulus ----------------
  int word_total = 0;

  task automatic add_word(logic [31:0] w, logic [2:0] nb, logic lst, logic cmp);
    pending_words.push_back('{word: w, nbytes: nb, last: lst, cmp: cmp, is_cfg: 1'b0,
                              cfg_word: '0, drain: 1'b0});
    word_total++;
  endtask

  task automatic add_cfg(logic [31:0] c);
    pending_words.push_back('{word: '0, nbytes: '0, last: 1'b0, cmp: 1'b0, is_cfg: 1'b1,
                              cfg_word: c, drain: 1'b1});
  endtask

  task automatic add_pause();
    pending_words.push_back('{word: '0, nbytes: '0, last: 1'b0, cmp: 1'b0, is_cfg: 1'b0,
                              cfg_word: '0, drain: 1'b1});
  endtask

  // well-formed message of n full words, random tail
  task automatic add_message(int n, bit cmp);
    for (int i = 0; i < n; i++) add_word($urandom, 3'd4, 1'b0, 1'b0);
    add_word($urandom, $urandom_range(0, 4), 1'b1, cmp);
  endtask

  task automatic random_cfg();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 3))
      0: c[31:24] = $urandom_range(MIN_EXP, MAX_EXP);
      1: c[31:24] = $urandom_range(29, MAX_EXP);
      default: ;
    endcase
    add_cfg(c);
  endtask

  initial begin
    new_message();
    load_target('0);
    // directed
    add_word(32'h0, 3'd0, 1'b1, 1'b1);              // empty message
    add_word(32'h61626300, 3'd3, 1'b1, 1'b1);       // "abc"
    add_word(32'hffffffff, 3'd7, 1'b0, 1'b0);       // excess bytes valid
    add_word(32'h12345678, 3'd1, 1'b0, 1'b1);       // short non-final word
    add_word(32'hffffffff, 3'd0, 1'b0, 1'b0);       // zero-byte word
    add_word(32'h00000000, 3'd5, 1'b1, 1'b0);
    add_cfg(32'h20ffffff);                           // max exponent: easy target
    add_message(19, 1'b1);                           // 76- to 80-byte message
    add_message(15, 1'b1);                           // 60 to 64 bytes: data block + pad block
    add_cfg(32'hffffffff);                           // out of range exponent
    add_word(32'hdeadbeef, 3'd4, 1'b1, 1'b1);
    add_cfg(32'h03ffffff);                           // min exponent
    add_word(32'hcafef00d, 3'd6, 1'b1, 1'b1);
    add_cfg(32'h02ffffff);
    add_word(32'h5a5a5a5a, 3'd2, 1'b1, 1'b1);
    add_cfg(32'h1d00ffff);
    add_pause();
    // random
    while (word_total < 1200) begin
      if ($urandom_range(0, 15) == 0) random_cfg();
      if ($urandom_range(0, 40) == 0) add_pause();
      case ($urandom_range(0, 9))
        0: add_word($urandom, $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1));
        1: add_message($urandom_range(30, 40), $urandom_range(0, 1));
        default: add_message($urandom_range(0, 20), $urandom_range(0, 1));
      endcase
    end
    add_cfg(32'h20ffffff);
    for (int i = 0; i < 4; i++) add_message(19, 1'b1);
    for (int i = 0; i < 6; i++) add_message($urandom_range(0, 19), $urandom_range(0, 1));
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    wait (word_total > 1200 && pending_words.size() < 150);
    quiet_tail = 1'b1;
    wait (stim_done && !s_axis_tvalid && expected_digests.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_digests.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
